// ===== design/nhc_pkg.sv =====
// Shared definitions for the normalized heat-map colormap.
// Holds register index codes, channel codes and the nine-point color ramp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nhc_pkg;

    localparam int SEG_SEL_BITS = 3;

    typedef enum logic [1:0] {
        CFG_RANGE_LOW   = 2'd0,
        CFG_RANGE_HIGH  = 2'd1,
        CFG_INVERT_RAMP = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_channel;

    typedef struct packed {
        logic valid;
        logic zero;
        logic one;
    } t_div_ctl;

    function automatic logic [7:0] ramp_point(input t_channel ch, input logic [3:0] idx);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        unique case (idx)
            4'd0: begin r = 8'd247; g = 8'd251; b = 8'd255; end
            4'd1: begin r = 8'd222; g = 8'd235; b = 8'd247; end
            4'd2: begin r = 8'd198; g = 8'd219; b = 8'd239; end
            4'd3: begin r = 8'd158; g = 8'd202; b = 8'd225; end
            4'd4: begin r = 8'd107; g = 8'd174; b = 8'd214; end
            4'd5: begin r = 8'd66;  g = 8'd146; b = 8'd198; end
            4'd6: begin r = 8'd33;  g = 8'd113; b = 8'd181; end
            4'd7: begin r = 8'd8;   g = 8'd81;  b = 8'd156; end
            default: begin r = 8'd8; g = 8'd48; b = 8'd107; end
        endcase
        unique case (ch)
            CH_RED:   return r;
            CH_GREEN: return g;
            default:  return b;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== design/nhc_div.sv =====
// Pipelined restoring divider producing the normalized fraction bits.
// One quotient bit per stage; depends on nhc_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module nhc_div #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire nhc_pkg::t_div_ctl        i_ctl,
    input  wire logic [SAMPLE_BITS-1:0]   i_num,
    input  wire logic [SAMPLE_BITS-1:0]   i_den,
    output nhc_pkg::t_div_ctl             o_ctl,
    output logic      [FRACTION_BITS-1:0] o_quot
);

    nhc_pkg::t_div_ctl        r_ctl  [FRACTION_BITS];
    logic [SAMPLE_BITS-1:0]   r_rem  [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] r_quot [FRACTION_BITS];

    for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_stage
        nhc_pkg::t_div_ctl        ctl_in;
        logic [SAMPLE_BITS-1:0]   rem_in;
        logic [FRACTION_BITS-1:0] quot_in;
        logic [SAMPLE_BITS:0]     shifted;
        logic [SAMPLE_BITS:0]     diff;
        logic                     ge;
        logic [SAMPLE_BITS-1:0]   n_rem;
        logic [FRACTION_BITS-1:0] n_quot;

        if (k == 0) begin : g_first
            assign ctl_in  = i_ctl;
            assign rem_in  = i_num;
            assign quot_in = '0;
        end else begin : g_next
            assign ctl_in  = r_ctl[k-1];
            assign rem_in  = r_rem[k-1];
            assign quot_in = r_quot[k-1];
        end

        always_comb begin
            shifted = {rem_in, 1'b0};
            diff    = shifted - {1'b0, i_den};
            ge      = (shifted >= {1'b0, i_den});
            n_rem   = ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            n_quot  = {quot_in[FRACTION_BITS-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].valid <= 1'b0;
            end else begin
                r_ctl[k].valid <= ctl_in.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ctl[k].zero <= ctl_in.zero;
            r_ctl[k].one  <= ctl_in.one;
            r_rem[k]      <= n_rem;
            r_quot[k]     <= n_quot;
        end
    end

    assign o_ctl  = r_ctl[FRACTION_BITS-1];
    assign o_quot = r_quot[FRACTION_BITS-1];

endmodule

`default_nettype wire

// ===== design/normalized_heatmap_colormap.sv =====
// Top level of the normalized heat-map colormap: range compare, divider, ramp lerp.
// Depends on nhc_pkg and nhc_div.
//
// Channel   Ports                               Beat taken when
// input     start, busy, i_sample               start && !busy
// result    o_valid, o_red, o_green, o_blue     o_valid (one cycle)
// config    i_cfg_we, i_cfg_idx, i_cfg_data     i_cfg_we
//
// One sample is accepted every cycle; busy is always low.
// Registers in order: input, one-bit-per-stage divider, products, outputs.
// Synchronous reset clears all valid bits; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module normalized_heatmap_colormap #(
    parameter int FRACTION_BITS = 12,
    parameter int SAMPLE_BITS   = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_cfg_we,
    input  wire logic        [1:0]             i_cfg_idx,
    input  wire logic        [SAMPLE_BITS-1:0] i_cfg_data,
    output logic                               o_valid,
    output logic             [7:0]             o_red,
    output logic             [7:0]             o_green,
    output logic             [7:0]             o_blue
);

    localparam int SEG_BITS = FRACTION_BITS - nhc_pkg::SEG_SEL_BITS;
    localparam int PROD_BITS = 8 + SEG_BITS + 1;
    localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [SEG_BITS:0] SEG_SPAN = {1'b1, {SEG_BITS{1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_range_low;
    logic signed [SAMPLE_BITS-1:0] r_range_high;
    logic                          r_invert;
    logic        [SAMPLE_BITS-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r_invert     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nhc_pkg::CFG_RANGE_LOW:   r_range_low  <= i_cfg_data;
                nhc_pkg::CFG_RANGE_HIGH:  r_range_high <= i_cfg_data;
                nhc_pkg::CFG_INVERT_RAMP: r_invert     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [SAMPLE_BITS:0] n_den_wide;
    assign n_den_wide = {r_range_high[SAMPLE_BITS-1], r_range_high}
                      - {r_range_low[SAMPLE_BITS-1], r_range_low};

    always_ff @(posedge i_clk) begin
        r_den <= n_den_wide[SAMPLE_BITS-1:0];
    end

    assign busy = 1'b0;

    // Range compare and offset.
    logic signed [SAMPLE_BITS:0]   n_diff_wide;
    logic                          n_zero;
    logic                          n_one;
    nhc_pkg::t_div_ctl             r_ctl0;
    logic        [SAMPLE_BITS-1:0] r_num;

    always_comb begin
        n_diff_wide = {i_sample[SAMPLE_BITS-1], i_sample}
                    - {r_range_low[SAMPLE_BITS-1], r_range_low};
        n_zero = (r_range_high <= r_range_low) || (i_sample <= r_range_low);
        n_one  = !n_zero && (i_sample >= r_range_high);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0.valid <= 1'b0;
        end else begin
            r_ctl0.valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl0.zero <= n_zero;
        r_ctl0.one  <= n_one;
        r_num       <= n_diff_wide[SAMPLE_BITS-1:0];
    end

    nhc_pkg::t_div_ctl          div_ctl;
    logic [FRACTION_BITS-1:0]   div_quot;

    nhc_div #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl0),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_ctl   (div_ctl),
        .o_quot  (div_quot)
    );

    // Segment select and weighted ramp points.
    logic [FRACTION_BITS:0] n_frac;
    logic [FRACTION_BITS:0] n_frac_dir;
    logic [3:0]             n_seg_raw;
    logic [3:0]             n_seg;
    logic [SEG_BITS:0]      n_t;
    logic [SEG_BITS:0]      n_w;
    logic                   r_valid_a;
    logic [PROD_BITS-1:0]   r_prod_a [3];
    logic [PROD_BITS-1:0]   r_prod_b [3];

    always_comb begin
        if (div_ctl.one) begin
            n_frac = FRAC_ONE;
        end else if (div_ctl.zero) begin
            n_frac = '0;
        end else begin
            n_frac = {1'b0, div_quot};
        end
        n_frac_dir = r_invert ? (FRAC_ONE - n_frac) : n_frac;
        n_seg_raw  = n_frac_dir[FRACTION_BITS:SEG_BITS];
        n_seg      = n_seg_raw[3] ? 4'd7 : n_seg_raw;
        n_t        = n_seg_raw[3] ? SEG_SPAN : {1'b0, n_frac_dir[SEG_BITS-1:0]};
        n_w        = SEG_SPAN - n_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else begin
            r_valid_a <= div_ctl.valid;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [7:0] pt_lo;
        logic [7:0] pt_hi;
        logic [PROD_BITS:0] sum;

        assign pt_lo = nhc_pkg::ramp_point(nhc_pkg::t_channel'(c), n_seg);
        assign pt_hi = nhc_pkg::ramp_point(nhc_pkg::t_channel'(c), n_seg + 4'd1);

        always_ff @(posedge i_clk) begin
            r_prod_a[c] <= PROD_BITS'(pt_lo) * PROD_BITS'(n_w);
            r_prod_b[c] <= PROD_BITS'(pt_hi) * PROD_BITS'(n_t);
        end

        assign sum = {1'b0, r_prod_a[c]} + {1'b0, r_prod_b[c]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        o_red   <= g_chan[0].sum[SEG_BITS +: 8];
        o_green <= g_chan[1].sum[SEG_BITS +: 8];
        o_blue  <= g_chan[2].sum[SEG_BITS +: 8];
    end

endmodule

`default_nettype wire

// ===== design/nhc_chk.sv =====
// Port-level checker for the normalized heat-map colormap, bound to the top level.
// Checks result timing and the color bounds of the ramp; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module nhc_chk #(
    parameter int FRACTION_BITS = 12
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [7:0] o_red,
    input wire logic [7:0] o_green,
    input wire logic [7:0] o_blue
);

    localparam int LATENCY = FRACTION_BITS + 3;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result beat missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_valid)
        else $error("result beat without input beat");

    a_color_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red >= 8'd8 && o_red <= 8'd247 && o_green >= 8'd48
                     && o_green <= 8'd251 && o_blue >= 8'd107))
        else $error("color outside ramp bounds");

endmodule

bind normalized_heatmap_colormap nhc_chk #(
    .FRACTION_BITS (FRACTION_BITS)
) u_nhc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue)
);

`default_nettype wire

// ===== tb/normalized_heatmap_colormap_tb.sv =====
// Self-checking testbench for the normalized heat-map colormap top level.
// A predictor maps each accepted sample to its expected color; results are checked in order.
// Depends on nhc_pkg and the design files under design/.
`timescale 1ns / 1ps

module normalized_heatmap_colormap_tb;

    localparam int FRAC_W     = 12;
    localparam int SEG_W      = FRAC_W - 3;
    localparam int SEG_SPAN   = 1 << SEG_W;
    localparam int FRAC_ONE   = 1 << FRAC_W;
    localparam int SMP_W      = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic signed [SMP_W-1:0] SMP_MIN = -24'sd8388608;
    localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sd8388607;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    start      = 1'b0;
    logic                    busy;
    logic signed [SMP_W-1:0] i_sample   = '0;
    logic                    i_cfg_we   = 1'b0;
    logic [1:0]              i_cfg_idx  = '0;
    logic [SMP_W-1:0]        i_cfg_data = '0;
    logic                    o_valid;
    logic [7:0]              o_red;
    logic [7:0]              o_green;
    logic [7:0]              o_blue;

    int ramp_red   [0:8] = '{247, 222, 198, 158, 107, 66, 33, 8, 8};
    int ramp_green [0:8] = '{251, 235, 219, 202, 174, 146, 113, 81, 48};
    int ramp_blue  [0:8] = '{255, 247, 239, 225, 214, 198, 181, 156, 107};

    logic signed [SMP_W-1:0] map_low    = 24'sd0;
    logic signed [SMP_W-1:0] map_high   = 24'sd8388607;
    logic                    map_invert = 1'b0;

    t_rgb expected_colors [$];
    t_rgb oldest_color;
    int   error_count = 0;
    int   cycle_count = 0;

    normalized_heatmap_colormap DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_sample   (i_sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int blend(int lo_pt, int hi_pt, int t);
        return ((lo_pt * (SEG_SPAN - t) + hi_pt * t) >> SEG_W) & 8'hFF;
    endfunction

    function automatic t_rgb predict_color(logic signed [SMP_W-1:0] smp);
        longint lo_v;
        longint hi_v;
        longint s_v;
        longint frac;
        int     seg;
        int     t;
        t_rgb   c;
        lo_v = map_low;
        hi_v = map_high;
        s_v  = smp;
        if (hi_v <= lo_v || s_v <= lo_v) begin
            frac = 0;
        end else if (s_v >= hi_v) begin
            frac = FRAC_ONE;
        end else begin
            frac = ((s_v - lo_v) << FRAC_W) / (hi_v - lo_v);
        end
        if (map_invert) begin
            frac = FRAC_ONE - frac;
        end
        seg = int'(frac >> SEG_W);
        if (seg > 7) begin
            seg = 7;
        end
        t = int'(frac) - seg * SEG_SPAN;
        c.red   = 8'(blend(ramp_red[seg],   ramp_red[seg+1],   t));
        c.green = 8'(blend(ramp_green[seg], ramp_green[seg+1], t));
        c.blue  = 8'(blend(ramp_blue[seg],  ramp_blue[seg+1],  t));
        return c;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 0, 1);
                end else begin
                    oldest_color = expected_colors.pop_front();
                    if (o_red !== oldest_color.red)
                        report_mismatch("red", oldest_color.red, o_red);
                    if (o_green !== oldest_color.green)
                        report_mismatch("green", oldest_color.green, o_green);
                    if (o_blue !== oldest_color.blue)
                        report_mismatch("blue", oldest_color.blue, o_blue);
                end
            end else if (o_valid !== 1'b0) begin
                report_mismatch("o_valid unknown", 0, 1);
            end
        end
    end

    // Leaves start high on return so that back-to-back beats need no extra edge.
    task automatic send_sample(logic signed [SMP_W-1:0] smp);
        start    <= 1'b1;
        i_sample <= smp;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_colors.push_back(predict_color(smp));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_colors.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_register(logic [1:0] idx, logic [SMP_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            nhc_pkg::CFG_RANGE_LOW:   map_low    = data;
            nhc_pkg::CFG_RANGE_HIGH:  map_high   = data;
            nhc_pkg::CFG_INVERT_RAMP: map_invert = data[0];
            default: ;
        endcase
    endtask

    task automatic set_mapping(logic signed [SMP_W-1:0] lo, logic signed [SMP_W-1:0] hi,
                               logic [SMP_W-1:0] inv_word);
        drain_results();
        write_register(nhc_pkg::CFG_RANGE_LOW, lo);
        write_register(nhc_pkg::CFG_RANGE_HIGH, hi);
        write_register(nhc_pkg::CFG_INVERT_RAMP, inv_word);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_mapping();
        send_sample(24'sd0);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(24'sd4194304);
        send_sample(24'sd1);
    endtask

    task automatic test_ramp_extremes();
        set_mapping(SMP_MIN, SMP_MAX, 24'd0);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        send_sample(24'sd0);
        send_sample(-24'sd1);
        set_mapping(SMP_MIN, SMP_MAX, 24'hFFFFFF);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
    endtask

    task automatic test_empty_range();
        set_mapping(24'sd100, 24'sd100, 24'd0);
        send_sample(24'sd100);
        send_sample(-24'sd5);
        set_mapping(24'sd500, -24'sd500, 24'd1);
        send_sample(24'sd0);
    endtask

    task automatic test_segment_points();
        // With a span of one full fraction, the sample is the fraction itself.
        set_mapping(24'sd0, 24'sd4096, 24'd0);
        send_sample(24'sd511);
        send_sample(24'sd512);
        send_sample(24'sd3584);
        send_sample(24'sd4095);
        send_sample(24'sd4096);
    endtask

    task automatic test_spare_index();
        drain_results();
        write_register(CFG_SPARE, 24'($urandom));
        i_cfg_we <= 1'b0;
        send_sample(24'sd2048);
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample();
        longint lo_v;
        longint span;
        lo_v = map_low;
        span = longint'(map_high) - lo_v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                if (span > 0)
                    return SMP_W'(lo_v + longint'($urandom_range(0, int'(span))));
                return SMP_W'($urandom);
            end
            6: return SMP_W'($urandom);
            7: begin
                if ($urandom_range(0, 1))
                    return SMP_W'(lo_v + longint'($urandom_range(0, 2)) - 1);
                return SMP_W'(longint'(map_high) + longint'($urandom_range(0, 2)) - 1);
            end
            8: return $urandom_range(0, 1) ? SMP_MIN : SMP_MAX;
            default: return SMP_W'(lo_v + longint'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    task automatic random_mapping();
        longint a;
        longint b;
        longint lo_v;
        longint hi_v;
        a = longint'(signed'(SMP_W'($urandom)));
        b = longint'(signed'(SMP_W'($urandom)));
        case ($urandom_range(0, 5))
            0: begin
                lo_v = (a < b) ? a : b;
                hi_v = (a < b) ? b : a;
                if (lo_v == hi_v) hi_v = lo_v + 1;
            end
            1: begin
                lo_v = longint'($urandom_range(0, (1 << SMP_W) - 66)) - (1 << (SMP_W - 1));
                hi_v = lo_v + longint'($urandom_range(1, 64));
            end
            2: begin
                lo_v = (a < b) ? b : a;
                hi_v = $urandom_range(0, 1) ? lo_v : ((a < b) ? a : b);
            end
            3: begin
                lo_v = SMP_MIN;
                hi_v = SMP_MAX;
            end
            default: begin
                lo_v = a;
                hi_v = b;
            end
        endcase
        set_mapping(SMP_W'(lo_v), SMP_W'(hi_v), SMP_W'($urandom));
    endtask

    task automatic test_random_stream();
        int burst_left;
        int gap;
        burst_left = 0;
        for (int phase = 0; phase < 12; phase++) begin
            random_mapping();
            for (int n = 0; n < 160; n++) begin
                if (phase == 5 && n == 80) begin
                    drain_results();
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
                    if (gap != 0) begin
                        start <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                send_sample(pick_sample());
                burst_left--;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_mapping();
        test_ramp_extremes();
        test_empty_range();
        test_segment_points();
        test_spare_index();
        test_random_stream();
        drain_results();
        repeat (FRAC_W + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/nhc_pkg.sv
design/nhc_div.sv
design/normalized_heatmap_colormap.sv
design/nhc_chk.sv
tb/normalized_heatmap_colormap_tb.sv
